>>> rtl/xcrc_pkg.sv
`timescale 1ns / 1ps

package xcrc_pkg;

  // Frame geometry: lead byte, block number, complement, payload, CRC high, CRC low.
  localparam int unsigned PAYLOAD_BYTES = 128;
  localparam logic [7:0] POS_LEAD   = 8'd0;
  localparam logic [7:0] POS_BLOCK  = 8'd1;
  localparam logic [7:0] POS_COMPL  = 8'd2;
  localparam logic [7:0] POS_DATA   = 8'd3;
  localparam logic [7:0] POS_CRC_HI = 8'(3 + PAYLOAD_BYTES);
  localparam logic [7:0] POS_CRC_LO = 8'(4 + PAYLOAD_BYTES);

  localparam logic [7:0] LEAD_SOH  = 8'h01;
  localparam logic [7:0] LEAD_EOT  = 8'h04;
  localparam logic [7:0] LEAD_CAN  = 8'h18;
  localparam logic [7:0] REPLY_C   = 8'h43;
  localparam logic [7:0] REPLY_ACK = 8'h06;
  localparam logic [7:0] REPLY_NAK = 8'h15;
  localparam logic [7:0] REPLY_CAN = 8'h18;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [8:0]  COMPL_SUM = 9'd255;

  localparam logic [7:0] MAX_ERRORS_RESET = 8'd10;
  localparam logic [7:0] ERROR_COUNT_MAX  = 8'd255;

  localparam logic REG_MAX_ERRORS     = 1'b0;
  localparam logic REG_REQUEST_ENABLE = 1'b1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [6:0] payload_index;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       frame_accepted;
    logic       number_error;
    logic       crc_error;
    logic       header_error;
    logic       transfer_done;
    logic       transfer_aborted;
  } result_t;

  // CRC-16/XMODEM, MSB first, one byte per call.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/xmodem_crc_packet_receiver_core.sv
`timescale 1ns / 1ps

// XMODEM-CRC receiver core for 128-byte SOH frames. Each input transaction is
// either a byte received from the link (op 0) or a request tick (op 1), and
// each one yields exactly one registered result transaction. A tick
// answers 'C' until the first complete frame has been seen, if request_enable
// is set. Payload bytes are forwarded as they arrive together with their index
// in the frame; they are tentative until the frame ends with frame_accepted and
// an ACK reply. A bad block number, complement or CRC gives NAK; a lead byte
// other than SOH, EOT or CAN (1024-byte STX frames included) is a header error.
// Errors accumulate over the transfer and reaching max_errors replies CAN and
// aborts. EOT is acknowledged and ends the transfer; a received CAN aborts
// without a reply. Either end of transfer restarts the protocol state.
// Throughput is one transaction per clock: the bytewise CRC update and the
// frame checks sit between the state registers and a single result register,
// and a new transaction is taken whenever that result register is empty or is
// being drained in the same cycle. Configuration writes are always taken and
// are meant to happen only while no transaction is in flight.
module xmodem_crc_packet_receiver_core
  import xcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] rx_byte,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic [6:0] payload_index,
  output logic       reply_valid,
  output logic [7:0] reply_byte,
  output logic       frame_accepted,
  output logic       number_error,
  output logic       crc_error,
  output logic       header_error,
  output logic       transfer_done,
  output logic       transfer_aborted
);

  // Configuration registers.
  logic [7:0] max_errors;
  logic       request_enable;

  // Protocol state.
  logic [7:0]  byte_position;
  logic [7:0]  expected_block;
  logic [7:0]  block_number;
  logic [7:0]  block_complement;
  logic [15:0] crc_running;
  logic [7:0]  crc_high_byte;
  logic [7:0]  error_count;
  logic        first_frame_seen;

  logic [7:0]  byte_position_next;
  logic [7:0]  expected_block_next;
  logic [7:0]  block_number_next;
  logic [7:0]  block_complement_next;
  logic [15:0] crc_running_next;
  logic [7:0]  crc_high_byte_next;
  logic [7:0]  error_count_next;
  logic        first_frame_seen_next;

  // Result register.
  result_t result;
  result_t result_next;

  logic        in_fire;
  logic        error_hit;
  logic        restart;
  logic [7:0]  error_count_inc;
  logic [15:0] rx_crc;
  logic        num_bad;
  logic        crc_bad;

  // The result register is the only buffer; it can refill in the cycle it drains.
  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign rx_crc  = {crc_high_byte, rx_byte};
  assign num_bad = (block_number != expected_block) ||
                   (({1'b0, block_number} + {1'b0, block_complement}) != COMPL_SUM);
  assign crc_bad = (rx_crc != crc_running);
  assign error_count_inc = (error_count == ERROR_COUNT_MAX) ? error_count
                                                            : error_count + 8'd1;

  always_comb begin
    byte_position_next    = byte_position;
    expected_block_next   = expected_block;
    block_number_next     = block_number;
    block_complement_next = block_complement;
    crc_running_next      = crc_running;
    crc_high_byte_next    = crc_high_byte;
    error_count_next      = error_count;
    first_frame_seen_next = first_frame_seen;
    result_next           = '0;
    error_hit             = 1'b0;
    restart               = 1'b0;

    if (op == OP_TICK) begin
      // A tick never disturbs a partial frame.
      if (request_enable && !first_frame_seen) begin
        result_next.reply_valid = 1'b1;
        result_next.reply_byte  = REPLY_C;
      end
    end else if (byte_position == POS_LEAD || byte_position > POS_CRC_LO) begin
      case (rx_byte)
        LEAD_SOH: begin
          byte_position_next = POS_BLOCK;
          crc_running_next   = '0;
        end
        LEAD_EOT: begin
          result_next.reply_valid   = 1'b1;
          result_next.reply_byte    = REPLY_ACK;
          result_next.transfer_done = 1'b1;
          restart                   = 1'b1;
        end
        LEAD_CAN: begin
          result_next.transfer_aborted = 1'b1;
          restart                      = 1'b1;
        end
        default: begin
          result_next.header_error = 1'b1;
          error_hit                = 1'b1;
        end
      endcase
    end else if (byte_position == POS_BLOCK) begin
      block_number_next  = rx_byte;
      byte_position_next = POS_COMPL;
    end else if (byte_position == POS_COMPL) begin
      block_complement_next = rx_byte;
      byte_position_next    = POS_DATA;
    end else if (byte_position < POS_CRC_HI) begin
      crc_running_next            = crc_update(crc_running, rx_byte);
      result_next.payload_valid   = 1'b1;
      result_next.payload_byte    = rx_byte;
      result_next.payload_index   = 7'(byte_position - POS_DATA);
      byte_position_next          = byte_position + 8'd1;
    end else if (byte_position == POS_CRC_HI) begin
      crc_high_byte_next = rx_byte;
      byte_position_next = POS_CRC_LO;
    end else begin
      // Last CRC byte: the frame is complete and gets checked.
      first_frame_seen_next = 1'b1;
      byte_position_next    = POS_LEAD;
      if (!num_bad && !crc_bad) begin
        result_next.frame_accepted = 1'b1;
        result_next.reply_valid    = 1'b1;
        result_next.reply_byte     = REPLY_ACK;
        expected_block_next        = expected_block + 8'd1;
      end else begin
        result_next.number_error = num_bad;
        result_next.crc_error    = crc_bad;
        error_hit                = 1'b1;
      end
    end

    // Shared error accounting for header errors and failed frames.
    if (error_hit) begin
      result_next.reply_valid = 1'b1;
      if (error_count_inc >= max_errors) begin
        result_next.reply_byte       = REPLY_CAN;
        result_next.transfer_aborted = 1'b1;
        restart                      = 1'b1;
      end else begin
        result_next.reply_byte = REPLY_NAK;
        error_count_next       = error_count_inc;
        byte_position_next     = POS_LEAD;
      end
    end

    // End of transfer returns the protocol to its power-up state.
    if (restart) begin
      byte_position_next    = POS_LEAD;
      expected_block_next   = 8'd1;
      block_number_next     = '0;
      block_complement_next = '0;
      crc_running_next      = '0;
      crc_high_byte_next    = '0;
      error_count_next      = '0;
      first_frame_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_errors     <= MAX_ERRORS_RESET;
      request_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_ERRORS:     max_errors     <= cfg_data;
        REG_REQUEST_ENABLE: request_enable <= cfg_data[0];
        default:            max_errors     <= max_errors;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= POS_LEAD;
      expected_block   <= 8'd1;
      block_number     <= '0;
      block_complement <= '0;
      crc_running      <= '0;
      crc_high_byte    <= '0;
      error_count      <= '0;
      first_frame_seen <= 1'b0;
    end else if (in_fire) begin
      byte_position    <= byte_position_next;
      expected_block   <= expected_block_next;
      block_number     <= block_number_next;
      block_complement <= block_complement_next;
      crc_running      <= crc_running_next;
      crc_high_byte    <= crc_high_byte_next;
      error_count      <= error_count_next;
      first_frame_seen <= first_frame_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The payload of the result register needs no reset; out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  assign payload_valid    = result.payload_valid;
  assign payload_byte     = result.payload_byte;
  assign payload_index    = result.payload_index;
  assign reply_valid      = result.reply_valid;
  assign reply_byte       = result.reply_byte;
  assign frame_accepted   = result.frame_accepted;
  assign number_error     = result.number_error;
  assign crc_error        = result.crc_error;
  assign header_error     = result.header_error;
  assign transfer_done    = result.transfer_done;
  assign transfer_aborted = result.transfer_aborted;

  // The frame position never runs past the last CRC byte.
  a_position_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_CRC_LO)
    else $error("byte position beyond frame end");

  // Any end of transfer leaves the protocol state restarted.
  a_restart_on_end: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (result_next.transfer_aborted || result_next.transfer_done)) |=>
      (error_count == 8'd0 && expected_block == 8'd1 && byte_position == POS_LEAD &&
       !first_frame_seen))
    else $error("transfer state not restarted after end of transfer");

  // A payload byte never comes with a reply in the same result.
  a_payload_no_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_valid) |-> !reply_valid)
    else $error("payload byte and reply in one result");

  // An accepted frame is always acknowledged.
  a_accept_acks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_accepted) |->
      (reply_valid && reply_byte == REPLY_ACK && !number_error && !crc_error))
    else $error("accepted frame without ACK");

  // Input backpressure only arises from a held result.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

endmodule

>>> test/xcrc_checker.sv
`timescale 1ns / 1ps

module xcrc_checker
  import xcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       op,
  input  logic [7:0] rx_byte,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       payload_valid,
  input  logic [7:0] payload_byte,
  input  logic [6:0] payload_index,
  input  logic       reply_valid,
  input  logic [7:0] reply_byte,
  input  logic       frame_accepted,
  input  logic       number_error,
  input  logic       crc_error,
  input  logic       header_error,
  input  logic       transfer_done,
  input  logic       transfer_aborted,
  output logic [7:0] next_block,
  output int         results_owed,
  output int         mismatches
);

  // Configuration and protocol state of the receiver as predicted here.
  logic [7:0]  limit_errors;
  logic        ask_crc_mode;
  logic [7:0]  frame_pos;
  logic [7:0]  block_due;
  logic [7:0]  hdr_block;
  logic [7:0]  hdr_compl;
  logic [15:0] crc_sum;
  logic [7:0]  crc_hi_rx;
  logic [7:0]  error_tally;
  logic        frame_seen;

  result_t owed_results[$];
  result_t observed;
  result_t oldest;

  assign next_block = block_due;

  // CRC-16/XMODEM, MSB first, one byte per call.
  function automatic logic [15:0] crc16_xmodem_next(input logic [15:0] acc,
                                                    input logic [7:0] data);
    logic [15:0] v;
    v = acc ^ {data, 8'h00};
    repeat (8) begin
      v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

  function automatic void restart_transfer_state();
    frame_pos   = POS_LEAD;
    block_due   = 8'd1;
    hdr_block   = 8'd0;
    hdr_compl   = 8'd0;
    crc_sum     = 16'd0;
    crc_hi_rx   = 8'd0;
    error_tally = 8'd0;
    frame_seen  = 1'b0;
  endfunction

  // A counted error either gives NAK or, at the limit, CAN and a fresh transfer.
  function automatic result_t charge_error(input result_t r_in);
    result_t r;
    r = r_in;
    if (error_tally != 8'hFF) begin
      error_tally = error_tally + 8'd1;
    end
    r.reply_valid = 1'b1;
    if (error_tally >= limit_errors) begin
      r.reply_byte       = REPLY_CAN;
      r.transfer_aborted = 1'b1;
      restart_transfer_state();
    end else begin
      r.reply_byte = REPLY_NAK;
      frame_pos    = POS_LEAD;
    end
    return r;
  endfunction

  function automatic result_t receiver_step(input logic kind, input logic [7:0] b);
    result_t r;
    logic    num_bad;
    logic    crc_bad;
    r = '0;
    if (kind == OP_TICK) begin
      if (ask_crc_mode && !frame_seen) begin
        r.reply_valid = 1'b1;
        r.reply_byte  = REPLY_C;
      end
    end else if (frame_pos == POS_LEAD) begin
      if (b == LEAD_SOH) begin
        frame_pos = POS_BLOCK;
        crc_sum   = 16'd0;
      end else if (b == LEAD_EOT) begin
        r.reply_valid   = 1'b1;
        r.reply_byte    = REPLY_ACK;
        r.transfer_done = 1'b1;
        restart_transfer_state();
      end else if (b == LEAD_CAN) begin
        r.transfer_aborted = 1'b1;
        restart_transfer_state();
      end else begin
        r.header_error = 1'b1;
        r = charge_error(r);
      end
    end else if (frame_pos == POS_BLOCK) begin
      hdr_block = b;
      frame_pos = POS_COMPL;
    end else if (frame_pos == POS_COMPL) begin
      hdr_compl = b;
      frame_pos = POS_DATA;
    end else if (frame_pos < POS_CRC_HI) begin
      crc_sum         = crc16_xmodem_next(crc_sum, b);
      r.payload_valid = 1'b1;
      r.payload_byte  = b;
      r.payload_index = 7'(frame_pos - POS_DATA);
      frame_pos       = frame_pos + 8'd1;
    end else if (frame_pos == POS_CRC_HI) begin
      crc_hi_rx = b;
      frame_pos = frame_pos + 8'd1;
    end else begin
      // The complement check is a plain sum, not a modulo-256 one.
      num_bad = (hdr_block != block_due) ||
                (({1'b0, hdr_block} + {1'b0, hdr_compl}) != 9'd255);
      crc_bad = ({crc_hi_rx, b} != crc_sum);
      frame_seen = 1'b1;
      frame_pos  = POS_LEAD;
      if (!num_bad && !crc_bad) begin
        r.frame_accepted = 1'b1;
        r.reply_valid    = 1'b1;
        r.reply_byte     = REPLY_ACK;
        block_due        = block_due + 8'd1;
      end else begin
        r.number_error = num_bad;
        r.crc_error    = crc_bad;
        r = charge_error(r);
      end
    end
    return r;
  endfunction

  function automatic logic fields_differ(input result_t a, input result_t b);
    return (a.payload_valid !== b.payload_valid) || (a.payload_byte !== b.payload_byte) ||
           (a.payload_index !== b.payload_index) || (a.reply_valid !== b.reply_valid) ||
           (a.reply_byte !== b.reply_byte) || (a.frame_accepted !== b.frame_accepted) ||
           (a.number_error !== b.number_error) || (a.crc_error !== b.crc_error) ||
           (a.header_error !== b.header_error) || (a.transfer_done !== b.transfer_done) ||
           (a.transfer_aborted !== b.transfer_aborted);
  endfunction

  function automatic string fields_text(input result_t r);
    return $sformatf({"pv=%0b pb=%02h pi=%0d rv=%0b rb=%02h acc=%0b num=%0b crc=%0b",
                      " hdr=%0b done=%0b abort=%0b"},
                     r.payload_valid, r.payload_byte, r.payload_index, r.reply_valid,
                     r.reply_byte, r.frame_accepted, r.number_error, r.crc_error,
                     r.header_error, r.transfer_done, r.transfer_aborted);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      owed_results.delete();
      restart_transfer_state();
      limit_errors = MAX_ERRORS_RESET;
      ask_crc_mode = 1'b1;
      results_owed = 0;
      mismatches   = 0;
    end else begin
      // Results are retired before new inputs are predicted; the block registers
      // every result, so this order never starves the queue.
      if (out_valid && !out_stall) begin
        observed = {payload_valid, payload_byte, payload_index, reply_valid, reply_byte,
                    frame_accepted, number_error, crc_error, header_error,
                    transfer_done, transfer_aborted};
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing owed: %s", $realtime, fields_text(observed));
          end
        end else begin
          oldest = owed_results.pop_front();
          if (fields_differ(oldest, observed)) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch\n  expected %s\n  actual   %s", $realtime,
                       fields_text(oldest), fields_text(observed));
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_ERRORS) begin
          limit_errors = cfg_data;
        end else begin
          ask_crc_mode = cfg_data[0];
        end
      end
      if (in_valid && !in_stall) begin
        owed_results.push_back(receiver_step(op, rx_byte));
      end
      results_owed = owed_results.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

// Testbench for the XMODEM-CRC receiver core. The top module only makes the
// stimulus and gives the verdict; xcrc_checker watches the three channels,
// predicts one result transaction per input transaction and compares them.
module tb;

  import xcrc_pkg::*;

  // How a frame is built. A cut frame stops early, so the receiver swallows
  // the following bytes as the rest of it; that keeps the misaligned paths busy.
  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CRC,
    FRAME_BAD_NUMBER,
    FRAME_BAD_COMPL,
    FRAME_CUT
  } frame_kind_e;

  // What goes into the payload of a frame.
  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_CONTROL
  } fill_style_e;

  // How the result side applies back-pressure during one stretch of cycles.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_COMB
  } stall_style_e;

  localparam int ITEM_GOAL      = 1350;
  localparam int SETTING_PERIOD = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       op = OP_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = REG_MAX_ERRORS;
  logic [7:0] cfg_data = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [6:0] payload_index;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic       frame_accepted;
  logic       number_error;
  logic       crc_error;
  logic       header_error;
  logic       transfer_done;
  logic       transfer_aborted;

  logic [7:0] next_block;
  int         results_owed;
  int         mismatches;

  // Sender bookkeeping: remaining transactions in the current burst, total
  // transactions sent, and the block number the receiver is waiting for as
  // seen just before the most recent transaction was accepted.
  int         burst_left = 0;
  int         items_sent = 0;
  logic [7:0] block_hint = 8'd1;

  stall_style_e stall_style = STALL_NONE;
  int           style_left = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  xmodem_crc_packet_receiver_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .rx_byte(rx_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .payload_valid(payload_valid), .payload_byte(payload_byte),
    .payload_index(payload_index), .reply_valid(reply_valid), .reply_byte(reply_byte),
    .frame_accepted(frame_accepted), .number_error(number_error), .crc_error(crc_error),
    .header_error(header_error), .transfer_done(transfer_done),
    .transfer_aborted(transfer_aborted)
  );

  xcrc_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .rx_byte(rx_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .payload_valid(payload_valid), .payload_byte(payload_byte),
    .payload_index(payload_index), .reply_valid(reply_valid), .reply_byte(reply_byte),
    .frame_accepted(frame_accepted), .number_error(number_error), .crc_error(crc_error),
    .header_error(header_error), .transfer_done(transfer_done),
    .transfer_aborted(transfer_aborted),
    .next_block(next_block), .results_owed(results_owed), .mismatches(mismatches)
  );

  // The result side stalls in stretches of random length. Each stretch has its
  // own style: no stalls at all, occasional stalls, mostly stalled, or a fixed
  // comb taken from the stretch counter, so stalls land on every phase of a frame.
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      stall_style <= STALL_NONE;
      style_left  <= 40;
    end else begin
      if (style_left == 0) begin
        stall_style <= stall_style_e'($urandom_range(0, 3));
        style_left  <= $urandom_range(20, 200);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          out_stall <= ($urandom_range(0, 4) == 0);
        end
        STALL_HEAVY: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= (style_left % 5 == 0) || (style_left % 7 == 3);
        end
      endcase
    end
  end

  // Offers one transaction and waits until it is taken. The sender works in
  // bursts; between bursts valid may drop for a random number of cycles.
  // Stall is looked at on the falling edge, where it is settled.
  task automatic send_item(input logic kind, input logic [7:0] data);
    int   gap;
    logic held;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    op       <= kind;
    rx_byte  <= data;
    do begin
      @(negedge clk);
      held       = in_stall;
      block_hint = next_block;
      @(posedge clk);
    end while (held);
    burst_left--;
    items_sent++;
  endtask

  // Stops sending and waits until every owed result has come back.
  task automatic hold_until_settled();
    in_valid  <= 1'b0;
    burst_left = 0;
    do begin
      @(negedge clk);
    end while (results_owed != 0);
    @(posedge clk);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_setting(input logic idx, input logic [7:0] value);
    logic taken;
    hold_until_settled();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_settings();
    logic [7:0] limit;
    case ($urandom_range(0, 4))
      0:       limit = 8'd1;
      1:       limit = 8'd255;
      default: limit = 8'($urandom_range(2, 12));
    endcase
    write_setting(REG_MAX_ERRORS, limit);
    write_setting(REG_REQUEST_ENABLE, 8'($urandom_range(0, 3) != 0));
  endtask

  // Sends one SOH frame. The block number is taken from what the receiver is
  // waiting for, so good frames really are accepted; the bad kinds break
  // exactly one check each, and a cut frame stops early. Ticks may be mixed
  // into the frame, which the receiver must answer without losing its place.
  task automatic send_frame(input frame_kind_e kind);
    logic [7:0]  blk;
    logic [7:0]  cpl;
    logic [7:0]  data;
    logic [15:0] crc;
    fill_style_e fill;
    int          tick_pct;
    int          last;
    crc      = 16'd0;
    fill     = fill_style_e'($urandom_range(0, 3));
    tick_pct = ($urandom_range(0, 3) == 0) ? 4 : 0;
    last     = (kind == FRAME_CUT) ? $urandom_range(0, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
    send_item(OP_BYTE, LEAD_SOH);
    blk = block_hint;
    cpl = 8'd255 - blk;
    case (kind)
      FRAME_BAD_NUMBER: begin
        // Wrong number with a matching complement, often a repeat of the last one.
        blk = ($urandom_range(0, 1) == 0) ? blk - 8'd1 : blk + 8'($urandom_range(1, 255));
        cpl = 8'd255 - blk;
      end
      FRAME_BAD_COMPL: begin
        cpl = cpl + 8'($urandom_range(1, 255));
      end
      default: begin
      end
    endcase
    send_item(OP_BYTE, blk);
    send_item(OP_BYTE, cpl);
    for (int k = 0; k < last; k++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end
      case (fill)
        FILL_ZERO: data = 8'h00;
        FILL_ONES: data = 8'hFF;
        FILL_CONTROL: begin
          case ($urandom_range(0, 4))
            0:       data = LEAD_SOH;
            1:       data = LEAD_EOT;
            2:       data = LEAD_CAN;
            3:       data = 8'h02;
            default: data = 8'($urandom_range(0, 255));
          endcase
        end
        default: data = 8'($urandom_range(0, 255));
      endcase
      crc = crc_update(crc, data);
      send_item(OP_BYTE, data);
    end
    if (kind != FRAME_CUT) begin
      if (kind == FRAME_BAD_CRC) begin
        crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      end
      send_item(OP_BYTE, crc[15:8]);
      send_item(OP_BYTE, crc[7:0]);
    end
  endtask

  initial begin
    int         pick;
    int         next_setting;
    logic [7:0] noise;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset settings (limit 10, requests on): a tick
    // asks for CRC mode, lead bytes 0x00, 0xFF and STX are header errors, EOT
    // is acknowledged and ends the transfer, CAN aborts without a reply.
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_BYTE, LEAD_EOT);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, LEAD_CAN);
    send_item(OP_TICK, 8'hA5);

    // Lowest limit with requests off: a tick gets no answer and the first
    // error hits the limit, so CAN goes out and the transfer restarts.
    write_setting(REG_MAX_ERRORS, 8'd1);
    write_setting(REG_REQUEST_ENABLE, 8'd0);
    send_item(OP_TICK, 8'h5A);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_TICK, 8'h00);

    // Highest limit with requests on, then a first frame that should pass.
    write_setting(REG_MAX_ERRORS, 8'd255);
    write_setting(REG_REQUEST_ENABLE, 8'd1);
    send_frame(FRAME_GOOD);

    // Random part. Most of it is frames with random content, so the checks at
    // frame end are exercised over and over; the rest is stray lead bytes,
    // ticks, EOT, CAN and pauses. The settings change every few hundred items.
    next_setting = items_sent + SETTING_PERIOD;
    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= next_setting) begin
        pick_settings();
        next_setting = items_sent + SETTING_PERIOD;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(FRAME_GOOD);
      end else if (pick < 62) begin
        send_frame(FRAME_BAD_CRC);
      end else if (pick < 68) begin
        send_frame(FRAME_BAD_NUMBER);
      end else if (pick < 73) begin
        send_frame(FRAME_BAD_COMPL);
      end else if (pick < 76) begin
        send_frame(FRAME_CUT);
      end else if (pick < 84) begin
        noise = ($urandom_range(0, 2) == 0) ? 8'h02 : 8'($urandom_range(0, 255));
        if (noise == LEAD_SOH || noise == LEAD_EOT || noise == LEAD_CAN) begin
          noise = 8'h02;
        end
        send_item(OP_BYTE, noise);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        send_item(OP_BYTE, LEAD_EOT);
      end else if (pick < 97) begin
        send_item(OP_BYTE, LEAD_CAN);
      end else begin
        // The sender goes quiet until the receiver has answered everything.
        hold_until_settled();
      end
    end

    // Drain, then give the block a few more cycles to show any stray result.
    hold_until_settled();
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/xcrc_pkg.sv
rtl/xmodem_crc_packet_receiver_core.sv
test/xcrc_checker.sv
test/tb.sv
